>>> design/htfl_pkg.sv
// Shared types and codes for the handle table allocator.
package htfl_pkg;

    localparam int unsigned PTR_W    = 64;
    localparam int unsigned HANDLE_W = 32;
    localparam int unsigned LIVE_W   = 11;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_LOOKUP     = 2'd2
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Write enables for the two slot memories.
    typedef struct packed {
        logic ptr;
        logic link;
    } t_store_we;

endpackage

>>> design/htfl_ifs.sv
// Request and response channel interfaces of the handle table allocator.
interface htfl_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic [htfl_pkg::PTR_W-1:0]      object_pointer;
    logic [htfl_pkg::HANDLE_W-1:0]   handle_in;

    modport source (output valid, output operation, output object_pointer,
                    output handle_in, input ready);
    modport sink   (input valid, input operation, input object_pointer,
                    input handle_in, output ready);
endinterface

interface htfl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [htfl_pkg::HANDLE_W-1:0]   handle_out;
    logic [htfl_pkg::PTR_W-1:0]      pointer_out;
    logic                            status;
    logic [htfl_pkg::LIVE_W-1:0]     live_entries;

    modport source (output valid, output handle_out, output pointer_out,
                    output status, output live_entries, input ready);
    modport sink   (input valid, input handle_out, input pointer_out,
                    input status, input live_entries, output ready);
endinterface

>>> design/htfl_store.sv
// Slot memories: pointer per slot and free-list link per slot.
module htfl_store #(
    parameter int unsigned SLOTS = 1024,
    parameter int unsigned IW    = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [IW-1:0]                 i_rd_addr,
    input  htfl_pkg::t_store_we           i_we,
    input  logic [IW-1:0]                 i_wr_addr,
    input  logic [htfl_pkg::PTR_W-1:0]    i_wr_ptr,
    input  logic [IW-1:0]                 i_wr_link,
    output logic [htfl_pkg::PTR_W-1:0]    o_rd_ptr,
    output logic [IW-1:0]                 o_rd_link
);
    import htfl_pkg::*;

    logic [PTR_W-1:0] r_ptr_mem  [SLOTS];
    logic [IW-1:0]    r_link_mem [SLOTS];
    logic [PTR_W-1:0] r_rd_ptr;
    logic [IW-1:0]    r_rd_link;

    always_ff @(posedge i_clk) begin
        if (i_we.ptr) begin
            r_ptr_mem[i_wr_addr] <= i_wr_ptr;
        end
        if (i_we.link) begin
            r_link_mem[i_wr_addr] <= i_wr_link;
        end
        if (i_rd_en) begin
            r_rd_ptr  <= r_ptr_mem[i_rd_addr];
            r_rd_link <= r_link_mem[i_rd_addr];
        end
    end

    assign o_rd_ptr  = r_rd_ptr;
    assign o_rd_link = r_rd_link;

endmodule

>>> design/handle_table_free_list_allocator_unit.sv
// Top level of the handle table allocator: request sequencer and result register.
//
// Usage: requests arrive on i_req (operation, object_pointer, handle_in) and
// each one yields exactly one word on o_rsp (handle_out, pointer_out, status,
// live_entries). A word moves when valid and ready are both high.
// Register hands out slot|bit31, taking the head of the LIFO free list first
// and the next fresh slot otherwise; unregister frees an occupied slot;
// lookup returns the stored pointer or zero. Slot 0 is the null handle.
// Timing: a request is taken in the idle cycle, the slot memories are read at
// that edge, and the execute state then reads, modifies and writes back and
// loads the result register. A new request is taken only once the last one
// has left the execute state, as the slot memories have a registered read.
// Stall: the result register holds while o_rsp.ready is low; one further
// request can still be taken and waits in its execute cycle until the result
// register frees up.
// Reset: clears the free list head, the fresh index (to 1), the live count
// and the handshake state. No clearing pass runs: any slot at or above the
// fresh index reads as free, so the pointer memory needs no sweep and the
// block takes requests straight out of reset.
module handle_table_free_list_allocator_unit #(
    parameter int unsigned SLOTS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htfl_req_if.sink   i_req,
    htfl_rsp_if.source o_rsp
);
    import htfl_pkg::*;

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = IW + 1;

    // control state
    t_state           r_state, n_state;
    logic [IW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_fresh, n_fresh;
    logic [CW-1:0]    r_live, n_live;
    logic             r_out_valid, n_out_valid;

    // captured request
    logic [1:0]       r_op;
    logic [PTR_W-1:0] r_ptr;
    logic [IW-1:0]    r_slot;
    logic             r_slot_ok;

    // result register
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [PTR_W-1:0]    r_pointer, n_pointer;
    logic                r_status, n_status;
    logic [LIVE_W-1:0]   r_out_live, n_out_live;

    // memory side
    logic             accept;
    logic             load;
    logic [IW-1:0]    rd_addr;
    logic [PTR_W-1:0] rd_ptr;
    logic [IW-1:0]    rd_link;
    logic [PTR_W-1:0] slot_ptr;
    logic [30:0]      req_idx;
    t_store_we        we;
    logic [IW-1:0]    wr_addr;
    logic [PTR_W-1:0] wr_ptr;

    assign accept  = i_req.valid && i_req.ready;
    assign load    = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);
    assign req_idx = i_req.handle_in[30:0];

    // Point the read at the free-list head for a register, else at the slot.
    assign rd_addr = (i_req.operation == OP_REGISTER) ? r_head : req_idx[IW-1:0];

    htfl_store #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_ptr  (wr_ptr),
        .i_wr_link (r_head),
        .o_rd_ptr  (rd_ptr),
        .o_rd_link (rd_link)
    );

    // Slots at or above the fresh index were never written since reset.
    assign slot_ptr = ({1'b0, r_slot} < r_fresh) ? rd_ptr : '0;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fresh     = r_fresh;
        n_live      = r_live;
        n_out_valid = r_out_valid;
        n_handle    = r_handle;
        n_pointer   = r_pointer;
        n_status    = r_status;
        n_out_live  = r_out_live;
        we          = '0;
        wr_addr     = r_slot;
        wr_ptr      = '0;
        i_req.ready = (r_state == ST_IDLE);

        // drop the result word once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (load) begin
                    n_state   = ST_IDLE;
                    n_handle  = '0;
                    n_pointer = '0;
                    n_status  = 1'b1;
                    case (r_op)
                        OP_REGISTER: begin
                            if (r_ptr != '0) begin
                                if (r_head != '0) begin
                                    // pop the free list
                                    wr_addr = r_head;
                                    n_head  = rd_link;
                                    we.ptr  = 1'b1;
                                end else if (r_fresh < CW'(SLOTS)) begin
                                    wr_addr = r_fresh[IW-1:0];
                                    n_fresh = r_fresh + 1'b1;
                                    we.ptr  = 1'b1;
                                end
                                if (we.ptr) begin
                                    wr_ptr   = r_ptr;
                                    n_live   = r_live + 1'b1;
                                    n_handle = {1'b1, (HANDLE_W - 1)'(wr_addr)};
                                    n_status = 1'b0;
                                end
                            end
                        end
                        OP_UNREGISTER: begin
                            if (r_slot_ok && slot_ptr != '0) begin
                                // clear the slot and push it on the list
                                we.ptr   = 1'b1;
                                we.link  = 1'b1;
                                n_head   = r_slot;
                                n_status = 1'b0;
                                if (r_live != '0) begin
                                    n_live = r_live - 1'b1;
                                end
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_slot_ok) begin
                                n_pointer = slot_ptr;
                                n_status  = (slot_ptr == '0);
                            end
                        end
                        default: begin
                            n_status = 1'b1;
                        end
                    endcase
                    n_out_live  = LIVE_W'(n_live);
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fresh     <= CW'(1);
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fresh     <= n_fresh;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the request and load the result word; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_req.operation;
            r_ptr     <= i_req.object_pointer;
            r_slot    <= req_idx[IW-1:0];
            r_slot_ok <= (req_idx != '0) && (req_idx < 31'(SLOTS));
        end
        r_handle   <= n_handle;
        r_pointer  <= n_pointer;
        r_status   <= n_status;
        r_out_live <= n_out_live;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.handle_out   = r_handle;
    assign o_rsp.pointer_out  = r_pointer;
    assign o_rsp.status       = r_status;
    assign o_rsp.live_entries = r_out_live;

endmodule
